[rtl/pu_pkg.sv]
// Shared types, widths and the factorial table for the permutation unrank block.
`default_nettype none

package pu_pkg;

    localparam int MAX_ELEMENTS = 12;
    localparam int LEN_W        = 4;
    localparam int ELEM_W       = 4;
    localparam int RANK_W       = 29;
    localparam int ARITH_W      = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int DIGIT_W      = 4;
    localparam int BIT_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDERING_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_APPLY,
        ST_LAST
    } t_state;

    typedef enum logic [1:0] {
        PERM_HOLD,
        PERM_INIT,
        PERM_ROTATE,
        PERM_SWAP
    } t_perm_op;

    // Factorial of k for k up to 12; codes above that never occur.
    function automatic logic [RANK_W-1:0] fact_of(input logic [LEN_W-1:0] k);
        logic [RANK_W-1:0] f;
        unique case (k)
            4'd0:    f = 29'd1;
            4'd1:    f = 29'd1;
            4'd2:    f = 29'd2;
            4'd3:    f = 29'd6;
            4'd4:    f = 29'd24;
            4'd5:    f = 29'd120;
            4'd6:    f = 29'd720;
            4'd7:    f = 29'd5040;
            4'd8:    f = 29'd40320;
            4'd9:    f = 29'd362880;
            4'd10:   f = 29'd3628800;
            4'd11:   f = 29'd39916800;
            4'd12:   f = 29'd479001600;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/pu_sub.sv]
// Shared subtract-and-compare unit used for the range check and every quotient bit.
`default_nettype none

module pu_sub (
    input  wire logic [pu_pkg::ARITH_W-1:0] i_a,
    input  wire logic [pu_pkg::ARITH_W-1:0] i_b,
    output logic      [pu_pkg::ARITH_W-1:0] o_diff,
    output logic                            o_borrow
);

    // A borrow means i_a is below i_b.
    assign {o_borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};

endmodule

`default_nettype wire

[rtl/pu_perm.sv]
// Permutation register row with rotate-to-front and swap-to-front updates.
`default_nettype none

module pu_perm #(
    parameter int MAX_ELEMENTS = pu_pkg::MAX_ELEMENTS
) (
    input  wire logic                              i_clk,
    input  wire pu_pkg::t_perm_op                  i_op,
    input  wire logic [$clog2(MAX_ELEMENTS)-1:0]   i_pos,
    input  wire logic [$clog2(MAX_ELEMENTS)-1:0]   i_sel,
    output logic      [pu_pkg::ELEM_W-1:0]         o_sel_value
);

    localparam int POS_W = $clog2(MAX_ELEMENTS);

    logic [pu_pkg::ELEM_W-1:0] r_perm [MAX_ELEMENTS];
    logic [pu_pkg::ELEM_W-1:0] w_pos_value;

    assign o_sel_value = r_perm[i_sel];
    assign w_pos_value = r_perm[i_pos];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            unique case (i_op)
                pu_pkg::PERM_INIT: begin
                    r_perm[k] <= pu_pkg::ELEM_W'(k);
                end
                pu_pkg::PERM_ROTATE: begin
                    // The chosen element moves to the front; the ones between shift back.
                    if (POS_W'(k) == i_pos) begin
                        r_perm[k] <= o_sel_value;
                    end else if (POS_W'(k) > i_pos && POS_W'(k) <= i_sel && k > 0) begin
                        r_perm[k] <= r_perm[(k > 0) ? k - 1 : 0];
                    end
                end
                pu_pkg::PERM_SWAP: begin
                    if (POS_W'(k) == i_pos) begin
                        r_perm[k] <= o_sel_value;
                    end else if (POS_W'(k) == i_sel) begin
                        r_perm[k] <= w_pos_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/permutation_unrank_top.sv]
// Top level of the permutation unrank block: sequencer, configuration registers, result port.
`default_nettype none

// A request on start/i_rank is taken when start is high and busy is low. The block turns
// the rank into the permutation of 0..n-1 with that rank, where n is length_in_use clamped
// to 2..MAX_ELEMENTS, and sends n results, one per position in order, each shown for exactly
// one cycle with o_strobe high; the last carries o_last_element. The receiver cannot stall
// the block, so results must be taken as they come. A rank of n! or more gives one result
// with o_rank_invalid and o_last_element set and element index 0. Order of work: after the
// accepting edge, the range check, then for each of the first n-1 positions four
// restoring-division steps for the digit through the one shared subtractor and an update of
// the permutation that sends the result, then the final result. Busy stays high until the
// last result is registered, so a new request can be taken only once the previous one is
// done; the last result is shown in the first cycle with busy low. For an invalid rank busy
// drops after the range check, and its result too is shown in the first cycle with
// busy low. The shared subtractor is why each digit is found by division steps in turn.
// Configuration writes are always taken and must only be issued while busy is low.

module permutation_unrank_top #(
    parameter int MAX_ELEMENTS = pu_pkg::MAX_ELEMENTS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [pu_pkg::RANK_W-1:0]       i_rank,
    output logic                                 o_strobe,
    output logic      [pu_pkg::ELEM_W-1:0]       o_element_index,
    output logic                                 o_last_element,
    output logic                                 o_rank_invalid,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int POS_W = $clog2(MAX_ELEMENTS);

    pu_pkg::t_state r_state, n_state;

    logic [pu_pkg::LEN_W-1:0]   r_length_in_use;
    logic                       r_ordering_mode;
    logic [pu_pkg::RANK_W-1:0]  r_rem;
    logic [POS_W-1:0]           r_pos;
    logic [pu_pkg::BIT_W-1:0]   r_bit;
    logic [pu_pkg::DIGIT_W-1:0] r_digit;

    logic                       r_strobe;
    logic [pu_pkg::ELEM_W-1:0]  r_element_index;
    logic                       r_last_element;
    logic                       r_rank_invalid;

    logic [pu_pkg::LEN_W-1:0]   w_len;
    logic [pu_pkg::LEN_W-1:0]   w_weight_k;
    logic [pu_pkg::ARITH_W-1:0] w_unit_a, w_unit_b, w_unit_diff;
    logic                       w_unit_borrow;
    logic [pu_pkg::DIGIT_W:0]   w_sel_sum;
    logic [POS_W-1:0]           w_sel, w_perm_sel;
    logic [pu_pkg::ELEM_W-1:0]  w_sel_value;
    pu_pkg::t_perm_op           w_perm_op;
    logic                       w_last_step;

    // Effective length: values below 2 count as 2, values above the row size as the row size.
    always_comb begin
        if (r_length_in_use < 4'd2) begin
            w_len = 4'd2;
        end else if (r_length_in_use > pu_pkg::LEN_W'(MAX_ELEMENTS)) begin
            w_len = pu_pkg::LEN_W'(MAX_ELEMENTS);
        end else begin
            w_len = r_length_in_use;
        end
    end

    // The digit at position pos weighs (n-1-pos)!.
    assign w_weight_k = w_len - 4'd1 - pu_pkg::LEN_W'(r_pos);

    // Selected element is pos + digit, clamped to the last position.
    assign w_sel_sum = {1'b0, r_digit} + (pu_pkg::DIGIT_W + 1)'(r_pos);
    always_comb begin
        if (w_sel_sum >= (pu_pkg::DIGIT_W + 1)'(w_len)) begin
            w_sel = POS_W'(w_len - 4'd1);
        end else begin
            w_sel = POS_W'(w_sel_sum);
        end
    end

    assign w_last_step = (pu_pkg::LEN_W'(r_pos) + 4'd1) == (w_len - 4'd1);

    assign w_unit_a = pu_pkg::ARITH_W'(r_rem);

    pu_sub u_sub (
        .i_a      (w_unit_a),
        .i_b      (w_unit_b),
        .o_diff   (w_unit_diff),
        .o_borrow (w_unit_borrow)
    );

    pu_perm #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_perm (
        .i_clk       (i_clk),
        .i_op        (w_perm_op),
        .i_pos       (r_pos),
        .i_sel       (w_perm_sel),
        .o_sel_value (w_sel_value)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pu_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = pu_pkg::ST_CHECK;
                end
            end
            pu_pkg::ST_CHECK: begin
                n_state = w_unit_borrow ? pu_pkg::ST_DIV : pu_pkg::ST_IDLE;
            end
            pu_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = pu_pkg::ST_APPLY;
                end
            end
            pu_pkg::ST_APPLY: begin
                n_state = w_last_step ? pu_pkg::ST_LAST : pu_pkg::ST_DIV;
            end
            pu_pkg::ST_LAST: begin
                n_state = pu_pkg::ST_IDLE;
            end
            default: begin
                n_state = pu_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls for each state.
    always_comb begin
        w_unit_b   = '0;
        w_perm_op  = pu_pkg::PERM_HOLD;
        w_perm_sel = w_sel;
        unique case (r_state)
            pu_pkg::ST_CHECK: begin
                w_unit_b  = pu_pkg::ARITH_W'(pu_pkg::fact_of(w_len));
                w_perm_op = pu_pkg::PERM_INIT;
            end
            pu_pkg::ST_DIV: begin
                w_unit_b = pu_pkg::ARITH_W'(pu_pkg::fact_of(w_weight_k)) << r_bit;
            end
            pu_pkg::ST_APPLY: begin
                w_perm_op = r_ordering_mode ? pu_pkg::PERM_ROTATE : pu_pkg::PERM_SWAP;
            end
            pu_pkg::ST_LAST: begin
                w_perm_sel = POS_W'(w_len - 4'd1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pu_pkg::ST_IDLE;
            r_length_in_use <= 4'd4;
            r_ordering_mode <= 1'b1;
            r_strobe        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pu_pkg::CFG_LENGTH_IN_USE: r_length_in_use <= i_cfg_data;
                    pu_pkg::CFG_ORDERING_MODE: r_ordering_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                pu_pkg::ST_CHECK: begin
                    // No borrow means the rank is at least n!: one flagged result.
                    if (!w_unit_borrow) begin
                        r_strobe <= 1'b1;
                    end
                end
                pu_pkg::ST_APPLY, pu_pkg::ST_LAST: begin
                    r_strobe <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pu_pkg::ST_IDLE: begin
                r_rem <= i_rank;
            end
            pu_pkg::ST_CHECK: begin
                r_pos           <= '0;
                r_bit           <= '1;
                r_digit         <= '0;
                r_element_index <= '0;
                r_last_element  <= 1'b1;
                r_rank_invalid  <= 1'b1;
            end
            pu_pkg::ST_DIV: begin
                // One restoring-division step: keep the difference when it does not borrow.
                if (!w_unit_borrow) begin
                    r_rem            <= w_unit_diff[pu_pkg::RANK_W-1:0];
                    r_digit[r_bit]   <= 1'b1;
                end
                r_bit <= r_bit - 1'b1;
            end
            pu_pkg::ST_APPLY: begin
                // Both orders place the selected element at the current position.
                r_element_index <= w_sel_value;
                r_last_element  <= 1'b0;
                r_rank_invalid  <= 1'b0;
                r_pos           <= r_pos + 1'b1;
                r_bit           <= '1;
                r_digit         <= '0;
            end
            pu_pkg::ST_LAST: begin
                r_element_index <= w_sel_value;
                r_last_element  <= 1'b1;
                r_rank_invalid  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign busy            = (r_state != pu_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_strobe        = r_strobe;
    assign o_element_index = r_element_index;
    assign o_last_element  = r_last_element;
    assign o_rank_invalid  = r_rank_invalid;

endmodule

`default_nettype wire
